/* rtl/core/cabb_pkg.sv */
// ----------------------------------------------------------------------------
// cabb_pkg
// Shared types and constants for the clipped alpha blend blitter.
// ----------------------------------------------------------------------------
package cabb_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PLACE_X       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PLACE_Y       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd5;

  // Field widths
  localparam int DEST_DIM_W = 13;
  localparam int PLACE_W    = 13;
  localparam int BMP_DIM_W  = 11;
  localparam int PIXEL_W    = 32;
  localparam int COORD_W    = 12;
  localparam int RGB_W      = 24;

  // Reset values of the configuration registers
  localparam logic [BMP_DIM_W-1:0] BMP_DIM_RESET = 11'd1;

  // Configuration as seen by the datapath (place_x/place_y are two's complement)
  typedef struct packed {
    logic [DEST_DIM_W-1:0] dest_width;
    logic [DEST_DIM_W-1:0] dest_height;
    logic [PLACE_W-1:0]    place_x;
    logic [PLACE_W-1:0]    place_y;
    logic [BMP_DIM_W-1:0]  bitmap_width;
    logic [BMP_DIM_W-1:0]  bitmap_height;
  } cfg_t;

  // Placement result for one pixel
  typedef struct packed {
    logic               write_enable;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic               last_pixel;
  } geom_t;

endpackage

/* rtl/core/cabb_cfg.sv */
// ----------------------------------------------------------------------------
// cabb_cfg
// APB-style register file holding framebuffer size, placement and bitmap size.
// ----------------------------------------------------------------------------
module cabb_cfg
  import cabb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  // Register write decode; unmapped indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DEST_WIDTH:    cfg_nxt.dest_width    = cfg_pwdata[DEST_DIM_W-1:0];
        REG_DEST_HEIGHT:   cfg_nxt.dest_height   = cfg_pwdata[DEST_DIM_W-1:0];
        REG_PLACE_X:       cfg_nxt.place_x       = cfg_pwdata[PLACE_W-1:0];
        REG_PLACE_Y:       cfg_nxt.place_y       = cfg_pwdata[PLACE_W-1:0];
        REG_BITMAP_WIDTH:  cfg_nxt.bitmap_width  = cfg_pwdata[BMP_DIM_W-1:0];
        REG_BITMAP_HEIGHT: cfg_nxt.bitmap_height = cfg_pwdata[BMP_DIM_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width    <= '0;
      cfg_r.dest_height   <= '0;
      cfg_r.place_x       <= '0;
      cfg_r.place_y       <= '0;
      cfg_r.bitmap_width  <= BMP_DIM_RESET;
      cfg_r.bitmap_height <= BMP_DIM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux; placement reads back sign-extended
  always_comb begin
    case (reg_idx)
      REG_DEST_WIDTH:    cfg_prdata = CFG_DATA_W'(cfg_r.dest_width);
      REG_DEST_HEIGHT:   cfg_prdata = CFG_DATA_W'(cfg_r.dest_height);
      REG_PLACE_X:       cfg_prdata = {{(CFG_DATA_W-PLACE_W){cfg_r.place_x[PLACE_W-1]}},
                                       cfg_r.place_x};
      REG_PLACE_Y:       cfg_prdata = {{(CFG_DATA_W-PLACE_W){cfg_r.place_y[PLACE_W-1]}},
                                       cfg_r.place_y};
      REG_BITMAP_WIDTH:  cfg_prdata = CFG_DATA_W'(cfg_r.bitmap_width);
      REG_BITMAP_HEIGHT: cfg_prdata = CFG_DATA_W'(cfg_r.bitmap_height);
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/cabb_locate.sv */
// ----------------------------------------------------------------------------
// cabb_locate
// Bitmap column/row counters, target coordinates and framebuffer clipping.
// ----------------------------------------------------------------------------
module cabb_locate
  import cabb_pkg::*;
#(
  parameter int MAX_DEST_DIM   = 4096,
  parameter int MAX_BITMAP_DIM = 1024
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  advance,
  output geom_t geom
);

  localparam int CNT_W  = $clog2(MAX_BITMAP_DIM);
  localparam int BMP_W  = (CNT_W + 1 > BMP_DIM_W) ? CNT_W + 1 : BMP_DIM_W;
  localparam int SUM_W  = ((CNT_W + 1 > PLACE_W) ? CNT_W + 1 : PLACE_W) + 1;
  localparam int DDIM_W = $clog2(MAX_DEST_DIM + 1) + 1;
  localparam int CMP_A  = (SUM_W > DDIM_W) ? SUM_W : DDIM_W;
  localparam int CMP_W  = (CMP_A > DEST_DIM_W + 1) ? CMP_A : DEST_DIM_W + 1;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;

  logic [BMP_W-1:0] bw_raw, bh_raw, bw_m1, bh_m1;
  logic             end_col, end_row;
  logic [CMP_W-1:0] tx, ty, dw_raw, dh_raw, dw, dh;
  logic             we;

  // Bitmap size, zero acts as one, clamped to the maximum
  assign bw_raw = BMP_W'(cfg.bitmap_width);
  assign bh_raw = BMP_W'(cfg.bitmap_height);

  always_comb begin
    if (bw_raw == '0) begin
      bw_m1 = '0;
    end else if (bw_raw > BMP_W'(MAX_BITMAP_DIM)) begin
      bw_m1 = BMP_W'(MAX_BITMAP_DIM - 1);
    end else begin
      bw_m1 = bw_raw - BMP_W'(1);
    end
    if (bh_raw == '0) begin
      bh_m1 = '0;
    end else if (bh_raw > BMP_W'(MAX_BITMAP_DIM)) begin
      bh_m1 = BMP_W'(MAX_BITMAP_DIM - 1);
    end else begin
      bh_m1 = bh_raw - BMP_W'(1);
    end
  end

  // At or past the last column/row counts as the last one
  assign end_col = BMP_W'(col_r) >= bw_m1;
  assign end_row = BMP_W'(row_r) >= bh_m1;

  // Target = placement + counters
  assign tx = {{(CMP_W-PLACE_W){cfg.place_x[PLACE_W-1]}}, cfg.place_x} + CMP_W'(col_r);
  assign ty = {{(CMP_W-PLACE_W){cfg.place_y[PLACE_W-1]}}, cfg.place_y} + CMP_W'(row_r);

  // Framebuffer size clamped to the maximum
  assign dw_raw = CMP_W'(cfg.dest_width);
  assign dh_raw = CMP_W'(cfg.dest_height);
  assign dw     = (dw_raw > CMP_W'(MAX_DEST_DIM)) ? CMP_W'(MAX_DEST_DIM) : dw_raw;
  assign dh     = (dh_raw > CMP_W'(MAX_DEST_DIM)) ? CMP_W'(MAX_DEST_DIM) : dh_raw;

  // Clip: both coordinates non-negative and below the framebuffer size
  assign we = !tx[CMP_W-1] && (tx < dw) && !ty[CMP_W-1] && (ty < dh);

  always_comb begin
    geom.write_enable = we;
    geom.target_x     = we ? tx[COORD_W-1:0] : '0;
    geom.target_y     = we ? ty[COORD_W-1:0] : '0;
    geom.last_pixel   = end_col & end_row;
  end

  // Raster-order counters, wrap after the last pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (end_col) begin
        col_nxt = '0;
        row_nxt = end_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/core/cabb_blend.sv */
// ----------------------------------------------------------------------------
// cabb_blend
// Per-channel alpha blend, round((255-a)*dst + a*src) / 255, halves up.
// ----------------------------------------------------------------------------
module cabb_blend
  import cabb_pkg::*;
(
  input  logic [PIXEL_W-1:0] src_pixel,
  input  logic [PIXEL_W-1:0] dst_pixel,
  input  logic               write_enable,
  output logic [RGB_W-1:0]   blended_rgb
);

  localparam int NCH = RGB_W / 8;

  logic [7:0]       alpha;
  logic [7:0]       alpha_inv;
  logic [RGB_W-1:0] rgb;

  assign alpha     = src_pixel[31:24];
  assign alpha_inv = 8'hFF - alpha;

  // One lane per color channel
  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    logic [15:0] prod_d, prod_s, sum, biased, quot;

    assign prod_d = alpha_inv * dst_pixel[8*ch +: 8];
    assign prod_s = alpha * src_pixel[8*ch +: 8];
    // sum <= 65025, biased <= 65152: fits 16 bits
    assign sum    = prod_d + prod_s;
    assign biased = sum + 16'd127;
    // Exact x/255 for x up to 65152: (x + (x >> 8) + 1) >> 8
    assign quot   = biased + (biased >> 8) + 16'd1;
    assign rgb[8*ch +: 8] = quot[15:8];
  end

  // Clipped pixels carry zero color
  assign blended_rgb = write_enable ? rgb : '0;

endmodule

/* rtl/core/clipped_alpha_blend_blit.sv */
// Pipeline: a word accepted into the input register moves on to the output register
// once that register is empty or taken, and is held there while out_stall is high.
// Throughput: one pixel per cycle while out_stall is low; the clip compare works on
// the counters ahead of the input register, the blend lanes sit between the input
// register and the output register.
// Reset (rst_n low, synchronous): counters to column 0 / row 0, pipeline emptied,
// registers to dest 0x0, place 0,0 and bitmap 1x1.
// ----------------------------------------------------------------------------
// clipped_alpha_blend_blit
// Blitter back end: locates each bitmap pixel in the framebuffer, clips it
// and blends it over the framebuffer pixel.
// ----------------------------------------------------------------------------
module clipped_alpha_blend_blit
  import cabb_pkg::*;
#(
  parameter int MAX_DEST_DIM   = 4096,
  parameter int MAX_BITMAP_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_W-1:0]    in_src_pixel,
  input  logic [PIXEL_W-1:0]    in_dst_pixel,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_write_enable,
  output logic [COORD_W-1:0]    out_target_x,
  output logic [COORD_W-1:0]    out_target_y,
  output logic [RGB_W-1:0]      out_blended_rgb,
  output logic                  out_last_pixel
);

  cfg_t  cfg;
  geom_t geom;
  logic  accept;
  logic  move;

  // Input stage registers
  logic               s1_valid_r, s1_valid_nxt;
  logic [PIXEL_W-1:0] s1_src_r;
  logic [PIXEL_W-1:0] s1_dst_r;
  geom_t              s1_geom_r;

  // Output stage registers
  logic               out_valid_r, out_valid_nxt;
  geom_t              out_geom_r;
  logic [RGB_W-1:0]   out_rgb_r;
  logic [RGB_W-1:0]   rgb_nxt;

  cabb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cabb_locate #(
    .MAX_DEST_DIM   (MAX_DEST_DIM),
    .MAX_BITMAP_DIM (MAX_BITMAP_DIM)
  ) u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (accept),
    .geom    (geom)
  );

  cabb_blend u_blend (
    .src_pixel    (s1_src_r),
    .dst_pixel    (s1_dst_r),
    .write_enable (s1_geom_r.write_enable),
    .blended_rgb  (rgb_nxt)
  );

  // Handshake: output register frees when empty or taken
  assign move     = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !move;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = move ? s1_valid_r : out_valid_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input stage payload: pixels plus the placement of this word
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r  <= in_src_pixel;
      s1_dst_r  <= in_dst_pixel;
      s1_geom_r <= geom;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (move && s1_valid_r) begin
      out_geom_r <= s1_geom_r;
      out_rgb_r  <= rgb_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_geom_r.write_enable;
  assign out_target_x     = out_geom_r.target_x;
  assign out_target_y     = out_geom_r.target_y;
  assign out_blended_rgb  = out_rgb_r;
  assign out_last_pixel   = out_geom_r.last_pixel;

endmodule
